// ===== rtl/pba_pkg.sv =====
// Package: types and constants for the page bitmap allocator.
`default_nettype none
package pba_pkg;
	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE  = 2'd1;
	localparam logic [1:0] MODE_COUNT = 2'd2;
	localparam logic [1:0] MODE_NOP   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BADADDR = 2'd2;

	localparam logic CFG_HEAP_BASE  = 1'b0;
	localparam logic CFG_PAGE_LIMIT = 1'b1;

	localparam int unsigned HEADER_BYTES = 8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN1,
		S_SCAN2,
		S_MARK,
		S_CLEAR,
		S_COUNT,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/page_bitmap_allocator.sv =====
// Top level: page bitmap allocator with next-fit search.
// From accept to result valid: count reads every managed page; free clears the pages given, up to the limit;
// allocate scans from the next-fit pointer, then from page zero, marks the n pages and finishes.
// Oversized allocate and the unused mode go straight to the result; next input the cycle after the result transfer.
// Reset clears the pointer and heap base, sets the page limit to 4096, then sweeps the bitmap
// free, one page a cycle, before the first input transfer is taken.
`default_nettype none
module page_bitmap_allocator
	import pba_pkg::*;
#(
	parameter int NUM_PAGES  = 4096,
	parameter int PAGE_BYTES = 4096
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// mode[1:0], request_bytes[33:2], free_address[65:34], free_pages[78:66], zeros
	input  wire  [79:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// status[1:0], block_address[33:2], first_page[45:34], page_count[58:46],
	// free_total[71:59], used_total[84:72], zeros
	output logic [87:0] m_tdata,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire  [31:0] cfg_data
);
	localparam int PW = $clog2(NUM_PAGES);
	localparam int CW = PW + 1;
	localparam int SH = $clog2(PAGE_BYTES);

	state_t state_q, state_d;
	logic [31:0] heap_base_q;
	logic [12:0] page_limit_q;
	logic [CW-1:0] next_q, ptr_q, run_q, need_q, start_q, cnt_q, lim_q;
	logic [1:0] mode_q;
	logic [CW:0] clr_q;
	logic clearing_q;
	logic [1:0] status_q;
	logic [31:0] addr_q;
	logic [11:0] fp_q;
	logic [12:0] pc_q, ft_q, ut_q;
	logic mem [NUM_PAGES];
	logic rd_q;
	logic [CW-1:0] rd_ptr_s1;
	logic rd_v_s1;

	wire [1:0]  in_mode = s_tdata[1:0];
	wire [31:0] in_req  = s_tdata[33:2];
	wire [31:0] in_fa   = s_tdata[65:34];
	wire [12:0] in_fp   = s_tdata[78:66];

	wire [CW-1:0] managed = ({{(CW > 13 ? CW-13 : 0){1'b0}}, page_limit_q} > CW'(NUM_PAGES))
		? CW'(NUM_PAGES) : CW'(page_limit_q);

	logic [32:0] bytes;
	logic [33:0] need_full;
	logic [32:0] fbase;
	logic [32:0] foff;
	logic [32:0] fpage;
	always_comb begin
		bytes = (in_req == 32'd0) ? 33'd1 : {1'b0, in_req};
		bytes = bytes + 33'(HEADER_BYTES) + 33'(PAGE_BYTES - 1);
		need_full = {1'b0, bytes} >> SH;
		fbase = {1'b0, heap_base_q} + 33'(HEADER_BYTES);
		foff = {1'b0, in_fa} - fbase;
		fpage = foff >> SH;
	end

	assign s_tready = (state_q == S_IDLE) && !clearing_q && !m_tvalid;
	assign cfg_ready = 1'b1;
	wire s_x = s_tvalid && s_tready;
	wire m_x = m_tvalid && m_tready;

	// bitmap access
	wire scanning = (state_q == S_SCAN1) || (state_q == S_SCAN2) || (state_q == S_COUNT);
	logic wr_en, wr_bit;
	logic [CW-1:0] wr_addr;
	always_comb begin
		wr_en = 1'b0;
		wr_bit = 1'b0;
		wr_addr = ptr_q;
		if (clearing_q) begin
			wr_en = 1'b1;
			wr_addr = clr_q[CW-1:0];
		end else if (state_q == S_MARK) begin
			wr_en = (cnt_q != '0);
			wr_bit = 1'b1;
		end else if (state_q == S_CLEAR) begin
			wr_en = (status_q == ST_OK) && (cnt_q != '0) && (ptr_q < lim_q);
		end
	end
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr[PW-1:0]] <= wr_bit;
		rd_q <= mem[ptr_q[PW-1:0]];
	end

	// scan with a registered read: issue ptr, evaluate returned bit next cycle
	wire in_rng = ptr_q < lim_q;
	wire hit = (state_q != S_COUNT) && rd_v_s1 && !rd_q && (run_q + 1'b1 == need_q);
	wire [CW-1:0] run_n = !rd_v_s1 ? run_q : (rd_q ? '0 : run_q + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			heap_base_q <= '0;
			page_limit_q <= 13'd4096;
			next_q <= '0;
			clr_q <= '0;
			clearing_q <= 1'b1;
			m_tvalid <= 1'b0;
			rd_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == (CW+1)'(NUM_PAGES - 1))
					clearing_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_HEAP_BASE)
					heap_base_q <= cfg_data;
				else
					page_limit_q <= cfg_data[12:0];
			end
			rd_v_s1 <= scanning && in_rng && !hit;
			if (m_x)
				m_tvalid <= 1'b0;
			if (state_q == S_DONE)
				m_tvalid <= 1'b1;
			if (s_x && in_mode == MODE_ALLOC && need_full > {{(34-CW){1'b0}}, managed})
				next_q <= '0;
			if (state_q == S_SCAN2 && !hit && !rd_v_s1 && !in_rng)
				next_q <= '0;
			if (state_q == S_MARK && cnt_q == '0)
				next_q <= ptr_q;
		end
	end

	always_ff @(posedge clk) begin
		rd_ptr_s1 <= ptr_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_x) begin
					mode_q <= in_mode;
					status_q <= ST_OK;
					addr_q <= '0; fp_q <= '0; pc_q <= '0; ft_q <= '0; ut_q <= '0;
					lim_q <= managed;
					run_q <= '0;
					cnt_q <= '0;
					need_q <= (need_full > {{(34-CW){1'b0}}, managed})
						? '0 : need_full[CW-1:0];
					ptr_q <= next_q;
					if (in_mode == MODE_ALLOC && need_full > {{(34-CW){1'b0}}, managed})
						status_q <= ST_NOSPACE;
					if (in_mode == MODE_COUNT)
						ptr_q <= '0;
					if (in_mode == MODE_FREE) begin
						if ({1'b0, in_fa} < fbase || fpage >= {{(33-CW){1'b0}}, managed})
							status_q <= ST_BADADDR;
						else begin
							ptr_q <= fpage[CW-1:0];
							fp_q <= fpage[11:0];
							cnt_q <= CW'(in_fp);
						end
					end
				end
			end
			S_SCAN1, S_SCAN2, S_COUNT: begin
				run_q <= run_n;
				if (state_q == S_COUNT && rd_v_s1)
					ut_q <= ut_q + 13'(rd_q);
				if (hit) begin
					start_q <= rd_ptr_s1 + 1'b1 - need_q;
					ptr_q <= rd_ptr_s1 + 1'b1 - need_q;
					cnt_q <= need_q;
				end else if (in_rng)
					ptr_q <= ptr_q + 1'b1;
				else if (!rd_v_s1 && state_q == S_SCAN1) begin
					ptr_q <= '0;
					run_q <= '0;
				end else if (!rd_v_s1 && state_q == S_SCAN2)
					status_q <= ST_NOSPACE;
				else if (!rd_v_s1 && state_q == S_COUNT)
					ft_q <= 13'(lim_q) - ut_q;
			end
			S_MARK: begin
				if (cnt_q == '0) begin
					addr_q <= heap_base_q + (32'(start_q) << SH) + 32'(HEADER_BYTES);
					fp_q <= start_q[11:0];
					pc_q <= 13'(need_q);
				end else begin
					ptr_q <= ptr_q + 1'b1;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			S_CLEAR: begin
				if (cnt_q != '0 && ptr_q < lim_q) begin
					ptr_q <= ptr_q + 1'b1;
					cnt_q <= cnt_q - 1'b1;
					pc_q <= pc_q + 13'd1;
				end
			end
			S_DONE: ;
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:
				if (s_x) begin
					unique case (in_mode)
						MODE_ALLOC: state_d = (need_full > {{(34-CW){1'b0}}, managed})
							? S_DONE : S_SCAN1;
						MODE_FREE: state_d = S_CLEAR;
						MODE_COUNT: state_d = S_COUNT;
						default: state_d = S_DONE;
					endcase
				end
			S_SCAN1:
				if (hit) state_d = S_MARK;
				else if (!in_rng && !rd_v_s1) state_d = S_SCAN2;
			S_SCAN2:
				if (hit) state_d = S_MARK;
				else if (!in_rng && !rd_v_s1) state_d = S_DONE;
			S_COUNT:
				if (!in_rng && !rd_v_s1) state_d = S_DONE;
			S_MARK:
				if (cnt_q == '0) state_d = S_DONE;
			S_CLEAR:
				if (status_q != ST_OK || cnt_q == '0 || !(ptr_q < lim_q)) state_d = S_DONE;
			S_DONE:
				state_d = S_IDLE;
			default:
				state_d = S_IDLE;
		endcase
	end

	wire bad = (status_q == ST_BADADDR) || (mode_q == MODE_ALLOC && status_q == ST_NOSPACE);
	assign m_tdata = {3'b000, ut_q, ft_q, bad ? 13'd0 : pc_q, bad ? 12'd0 : fp_q,
		bad ? 32'd0 : addr_q, status_q};
endmodule
`default_nettype wire

// ===== rtl/pba_checker.sv =====
// Checker: port-level assertions for the page bitmap allocator, with its bind.
`default_nettype none
module pba_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [87:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output not held");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("ready after accept");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("accept while result pending");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3) else $error("bad status");
endmodule
bind page_bitmap_allocator pba_checker u_pba_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));
`default_nettype wire

// ===== test/page_bitmap_allocator_test.sv =====
// Testbench for the page bitmap allocator: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module page_bitmap_allocator_test;
	import pba_pkg::*;

	localparam int MAP_PAGES = 4096;
	localparam int PG_BYTES = 4096;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		bit [1:0]  mode;
		bit [31:0] req_bytes;
		bit [31:0] free_addr;
		bit [12:0] free_cnt;
	} request_t;

	typedef struct {
		bit [1:0]  status;
		bit [31:0] block_addr;
		bit [11:0] first_pg;
		bit [12:0] pg_count;
		bit [12:0] free_tot;
		bit [12:0] used_tot;
	} reply_t;

	typedef struct {
		bit [31:0] addr;
		bit [12:0] pages;
	} block_t;

	typedef struct {
		bit        index;
		bit [31:0] data;
	} reg_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	page_bitmap_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// predictor state
	bit          page_used [MAP_PAGES];
	int unsigned next_pg;
	bit [31:0]   heap_base;
	bit [12:0]   page_lim;

	request_t    pending_q [$];
	reply_t      reply_q [$];
	reg_write_t  reg_q [$];
	block_t      live_q [$];

	int  sender_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  failed = 0;
	bit  hold_go = 0;
	bit  hold_done = 0;
	int  hold_cnt = 0;
	int  cycles = 0;

	function automatic bit find_free_run(input int unsigned from, input int unsigned lim,
			input int unsigned need, output int unsigned start);
		int unsigned run;
		run = 0;
		start = 0;
		for (int unsigned p = from; p < lim; p++) begin
			run = page_used[p] ? 0 : run + 1;
			if (run == need) begin
				start = p + 1 - need;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic reply_t apply_request(input request_t r);
		reply_t o;
		int unsigned lim, start, cnt, used;
		longint unsigned bytes, need, base8, pg;
		bit ok;
		o = '{default: 0};
		lim = (page_lim < MAP_PAGES) ? page_lim : MAP_PAGES;
		case (r.mode)
			MODE_ALLOC: begin
				bytes = (r.req_bytes == 0) ? 1 : r.req_bytes;
				bytes += HEADER_BYTES;
				need = (bytes + PG_BYTES - 1) / PG_BYTES;
				ok = 0;
				if (need <= lim) begin
					ok = find_free_run(next_pg, lim, 32'(need), start);
					if (!ok)
						ok = find_free_run(0, lim, 32'(need), start);
				end
				if (!ok) begin
					next_pg = 0;
					o.status = ST_NOSPACE;
				end else begin
					for (int unsigned p = start; p < start + need; p++)
						page_used[p] = 1;
					next_pg = 32'(start + need);
					o.status = ST_OK;
					o.block_addr = heap_base + 32'(start) * 32'(PG_BYTES) + 32'(HEADER_BYTES);
					o.first_pg = start[11:0];
					o.pg_count = need[12:0];
				end
			end
			MODE_FREE: begin
				base8 = longint'(heap_base) + HEADER_BYTES;
				if (longint'(r.free_addr) < base8) begin
					o.status = ST_BADADDR;
				end else begin
					pg = (longint'(r.free_addr) - base8) / PG_BYTES;
					if (pg >= lim) begin
						o.status = ST_BADADDR;
					end else begin
						cnt = 0;
						for (int unsigned p = 32'(pg); p < lim && cnt < r.free_cnt; p++) begin
							page_used[p] = 0;
							cnt++;
						end
						o.first_pg = pg[11:0];
						o.pg_count = cnt[12:0];
					end
				end
			end
			MODE_COUNT: begin
				used = 0;
				for (int unsigned p = 0; p < lim; p++)
					used += page_used[p];
				o.free_tot = 13'(lim - used);
				o.used_tot = 13'(used);
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic send(input bit [1:0] mode, input bit [31:0] nbytes,
			input bit [31:0] addr, input bit [12:0] cnt);
		request_t r;
		reply_t o;
		r = '{mode, nbytes, addr, cnt};
		o = apply_request(r);
		pending_q.push_back(r);
		reply_q.push_back(o);
		if (mode == MODE_ALLOC && o.status == ST_OK)
			live_q.push_back('{o.block_addr, o.pg_count});
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || s_tvalid || reply_q.size() != 0 ||
				reg_q.size() != 0 || cfg_valid)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(input bit [31:0] base, input bit [12:0] lim);
		reg_q.push_back('{CFG_HEAP_BASE, base});
		reg_q.push_back('{CFG_PAGE_LIMIT, 32'(lim)});
		heap_base = base;
		page_lim = lim;
		live_q.delete();
		drain();
	endtask

	task automatic random_items(input int n);
		int unsigned lim, k, pick, idx;
		block_t b;
		lim = (page_lim < MAP_PAGES) ? page_lim : MAP_PAGES;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				if ($urandom_range(9) == 0) begin
					send(MODE_ALLOC, $urandom, $urandom, 13'($urandom));
				end else begin
					k = $urandom_range(1, (lim < 4) ? lim : 4);
					if (lim > 16 && $urandom_range(19) == 0)
						k = $urandom_range(1, lim);
					send(MODE_ALLOC, $urandom_range(0, k * PG_BYTES - 8), $urandom, 13'd0);
				end
			end else if (pick < 75 && live_q.size() != 0) begin
				idx = $urandom_range(0, live_q.size() - 1);
				b = live_q[idx];
				live_q.delete(idx);
				k = ($urandom_range(4) == 0) ? $urandom_range(0, b.pages + 2) : b.pages;
				send(MODE_FREE, $urandom, b.addr + (($urandom_range(3) == 0) ?
					$urandom_range(0, PG_BYTES - 1) : 0), 13'(k));
			end else if (pick < 85) begin
				if ($urandom_range(1))
					send(MODE_FREE, $urandom, $urandom, 13'($urandom_range(0, 4096)));
				else
					send(MODE_FREE, $urandom, heap_base + 8 +
						32'($urandom_range(0, lim + 3)) * PG_BYTES - $urandom_range(0, 16),
						13'($urandom_range(0, 6)));
			end else if (pick < 95) begin
				send(MODE_COUNT, $urandom, $urandom, 13'($urandom));
			end else begin
				send(MODE_NOP, $urandom, $urandom, 13'($urandom));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drv
		request_t r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				r = pending_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {1'b0, r.free_cnt, r.free_addr, r.req_bytes, r.mode};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : cfg_drv
		reg_write_t w;
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else if (!cfg_valid || cfg_ready) begin
			if (reg_q.size() != 0) begin
				w = reg_q.pop_front();
				cfg_valid <= 1'b1;
				cfg_index <= w.index;
				cfg_data <= w.data;
			end else begin
				cfg_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (hold_go && !hold_done) begin
			hold_cnt <= 600;
			hold_done <= 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin : mon
		reply_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (reply_q.size() == 0) begin
					$error("result transfer with nothing expected: %h", m_tdata);
					failed = 1;
				end else begin
					e = reply_q.pop_front();
					if (m_tdata[1:0] !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, m_tdata[1:0]);
						failed = 1;
					end
					if (m_tdata[33:2] !== e.block_addr) begin
						$error("block_address: expected %h, got %h", e.block_addr, m_tdata[33:2]);
						failed = 1;
					end
					if (m_tdata[45:34] !== e.first_pg) begin
						$error("first_page: expected %0d, got %0d", e.first_pg, m_tdata[45:34]);
						failed = 1;
					end
					if (m_tdata[58:46] !== e.pg_count) begin
						$error("page_count: expected %0d, got %0d", e.pg_count, m_tdata[58:46]);
						failed = 1;
					end
					if (m_tdata[71:59] !== e.free_tot) begin
						$error("free_total: expected %0d, got %0d", e.free_tot, m_tdata[71:59]);
						failed = 1;
					end
					if (m_tdata[84:72] !== e.used_tot) begin
						$error("used_total: expected %0d, got %0d", e.used_tot, m_tdata[84:72]);
						failed = 1;
					end
				end
			end
			m_tready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("page_bitmap_allocator_test: FAIL");
			$finish;
		end
	end

	initial begin
		for (int p = 0; p < MAP_PAGES; p++)
			page_used[p] = 0;
		next_pg = 0;
		heap_base = 0;
		page_lim = 13'd4096;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		send(MODE_ALLOC, 32'd0, 32'd0, 13'd0);
		send(MODE_ALLOC, 32'd4088, 32'd0, 13'd0);
		send(MODE_ALLOC, 32'd4089, 32'd0, 13'd0);
		send(MODE_ALLOC, 32'hFFFF_FFFF, 32'd0, 13'd0);
		send(MODE_COUNT, 32'd0, 32'd0, 13'd0);
		send(MODE_FREE, 32'd0, 32'd0, 13'd1);
		send(MODE_FREE, 32'd0, 32'd7, 13'd1);
		send(MODE_FREE, 32'd0, 32'd8, 13'd1);
		send(MODE_FREE, 32'd0, 32'd4104 + 32'd100, 13'd0);
		send(MODE_FREE, 32'd0, 32'hFFFF_FFFF, 13'h1FFF);
		send(MODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'h1FFF);
		send(MODE_FREE, 32'd0, 32'd8, 13'd4096);
		send(MODE_ALLOC, 32'h00FF_FFF8, 32'd0, 13'd0);
		send(MODE_COUNT, 32'hFFFF_FFFF, 32'd0, 13'd0);
		send(MODE_ALLOC, 32'd1, 32'd0, 13'd0);
		send(MODE_FREE, 32'd0, 32'd8 + 32'd4095 * 4096, 13'd4096);
		send(MODE_ALLOC, 32'd4096, 32'd0, 13'd0);
		send(MODE_ALLOC, 32'h00FF_F000, 32'd0, 13'd0);
		send(MODE_FREE, 32'd0, 32'd8, 13'd4096);
		send(MODE_COUNT, 32'd0, 32'd0, 13'd0);
		drain();

		set_regs(32'h0000_1000, 13'd1);
		random_items(90);
		drain();

		sender_idle_pct = 52;
		set_regs(32'hFFFF_FFFF, 13'd8);
		random_items(90);
		drain();

		sender_idle_pct = 0;
		recv_stall_pct = 52;
		set_regs(32'h8000_0000, 13'd37);
		random_items(90);
		drain();

		sender_idle_pct = 22;
		recv_stall_pct = 22;
		set_regs($urandom, 13'd64);
		random_items(90);
		drain();

		sender_idle_pct = 0;
		recv_stall_pct = 0;
		set_regs(32'h1234_5000, 13'd4096);
		random_items(40);
		drain();

		set_regs($urandom, 13'd16);
		hold_go = 1;
		random_items(90);
		drain();

		sender_idle_pct = 52;
		recv_stall_pct = 52;
		set_regs(32'd0, 13'd3);
		random_items(90);
		drain();

		repeat (50) @(posedge clk);
		if (!failed)
			$display("page_bitmap_allocator_test: PASS");
		else
			$display("page_bitmap_allocator_test: FAIL");
		$finish;
	end
endmodule
